### sv/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the best-fit block allocator.
package bfa_pkg;

  localparam int ADDR_BITS = 24;
  localparam int REM_BITS  = 25;
  localparam int GAP_BITS  = 27;
  localparam int UNIT_BITS = 9;
  localparam int LOG_BITS  = 4;

  // Slot numbers of the two sentinel cells
  localparam int HEAD_SLOT = 0;
  localparam int TAIL_SLOT = 1;

  // Configuration register indexes and reset values
  localparam logic REG_UNIT_LOG2  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;
  localparam logic [LOG_BITS-1:0] UNIT_LOG2_RST  = 4'd4;
  localparam logic [REM_BITS-1:0] HEAP_BYTES_RST = 25'd65536;
  localparam logic [REM_BITS-1:0] HEAP_LIMIT     = 25'h1000000;

  typedef enum logic [1:0] {
    OP_INIT      = 2'd0,
    OP_ALLOC_FWD = 2'd1,
    OP_ALLOC_REV = 2'd2,
    OP_FREE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // Write enables of the cell store
  typedef struct packed {
    logic off_size;
    logic nxt;
    logic prv;
  } cell_we_t;

endpackage

### sv/bfa_cell_store.sv
`timescale 1ns / 1ps
// Cell table: offset, size and both links of every slot, one read port.
module bfa_cell_store #(
  parameter int SLOTS = 258
) (
  input  logic                             clk,
  input  bfa_pkg::cell_we_t                we,
  input  logic [$clog2(SLOTS)-1:0]         wr_idx,
  input  logic [bfa_pkg::ADDR_BITS-1:0]    off_d,
  input  logic [bfa_pkg::REM_BITS-1:0]     size_d,
  input  logic [$clog2(SLOTS)-1:0]         nxt_idx,
  input  logic [$clog2(SLOTS)-1:0]         nxt_d,
  input  logic [$clog2(SLOTS)-1:0]         prv_idx,
  input  logic [$clog2(SLOTS)-1:0]         prv_d,
  input  logic [$clog2(SLOTS)-1:0]         rd_idx,
  output logic [bfa_pkg::ADDR_BITS-1:0]    rd_off,
  output logic [bfa_pkg::REM_BITS-1:0]     rd_size,
  output logic [$clog2(SLOTS)-1:0]         rd_nxt,
  output logic [$clog2(SLOTS)-1:0]         rd_prv
);
  import bfa_pkg::*;

  localparam int SB = $clog2(SLOTS);

  logic [ADDR_BITS-1:0] off_mem  [SLOTS];
  logic [REM_BITS-1:0]  size_mem [SLOTS];
  logic [SB-1:0]        nxt_mem  [SLOTS];
  logic [SB-1:0]        prv_mem  [SLOTS];

  // Write offset and size at one address, and each link array at its own
  always_ff @(posedge clk) begin
    if (we.off_size) begin
      off_mem[wr_idx]  <= off_d;
      size_mem[wr_idx] <= size_d;
    end
    if (we.nxt) begin
      nxt_mem[nxt_idx] <= nxt_d;
    end
    if (we.prv) begin
      prv_mem[prv_idx] <= prv_d;
    end
  end

  // Registered read of one whole cell
  always_ff @(posedge clk) begin
    rd_off  <= off_mem[rd_idx];
    rd_size <= size_mem[rd_idx];
    rd_nxt  <= nxt_mem[rd_idx];
    rd_prv  <= prv_mem[rd_idx];
  end

endmodule

### sv/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Best-fit block allocator: control sequencer, spare slot stack and counters.
//
// Input beats carry an opcode (init, forward alloc, reverse alloc, free), the
// requested byte count and the address to free. Each input beat yields one
// result beat: status, payload address, free bytes and their low watermark.
// Registers unit_log2 and heap_bytes are written through the cfg_ port.
// One operation is in flight at a time. A free of null and any op refused up
// front go straight to the result. An alloc examines one gap per cycle through
// the cell store read port; a free walks the list until its block is found.
// in_stall is high while an operation is in flight.
// A finished result sits in the output register; while out_stall holds it
// there the next beat is still taken, and a further result waits in the
// sequencer until the register drains.
// After reset the heap is empty and unset: allocs answer table full and frees
// of a nonzero address answer unknown until the first init.
module best_fit_block_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [bfa_pkg::ADDR_BITS-1:0]  in_request_bytes,
  input  logic [bfa_pkg::ADDR_BITS-1:0]  in_free_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [bfa_pkg::ADDR_BITS-1:0]  out_address,
  output logic [bfa_pkg::REM_BITS-1:0]   out_remainder,
  output logic [bfa_pkg::REM_BITS-1:0]   out_remainder_min,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bfa_pkg::REM_BITS-1:0]   cfg_wdata
);
  import bfa_pkg::*;

  localparam int SLOTS = MAX_BLOCKS + 2;
  localparam int SB    = $clog2(SLOTS);
  localparam int CB    = $clog2(MAX_BLOCKS + 1);
  localparam int WB    = $clog2(SLOTS + 1);
  localparam logic [SB-1:0] HEAD = SB'(HEAD_SLOT);
  localparam logic [SB-1:0] TAIL = SB'(TAIL_SLOT);
  localparam logic [GAP_BITS-1:0] BEST_INIT = {1'b0, {(GAP_BITS-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_H, S_INIT_T, S_FIRST, S_WALK, S_PLACE, S_LINK,
    S_FREE_H, S_FREE_W, S_UNLINK, S_DONE
  } state_t;

  // Configuration registers
  logic [LOG_BITS-1:0] unit_log2_r;
  logic [REM_BITS-1:0] heap_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_log2_r  <= UNIT_LOG2_RST;
      heap_bytes_r <= HEAP_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_LOG2:  unit_log2_r  <= cfg_wdata[LOG_BITS-1:0];
        REG_HEAP_BYTES: heap_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t               state_r;
  logic                 inited_r;
  logic                 rev_r;
  logic [UNIT_BITS-1:0] unit_r;
  logic [REM_BITS-1:0]  need_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [REM_BITS-1:0]  size_r;
  logic [CB-1:0]        count_r;
  logic [CB-1:0]        low_r;
  logic [REM_BITS-1:0]  free_r;
  logic [REM_BITS-1:0]  free_low_r;
  logic [SB-1:0]        cur_r;
  logic [SB-1:0]        nx_r;
  logic [ADDR_BITS-1:0] cur_off_r;
  logic [REM_BITS-1:0]  cur_size_r;
  logic [WB-1:0]        cnt_r;
  logic [GAP_BITS-1:0]  best_r;
  logic                 found_r;
  logic [SB-1:0]        pick_r;
  logic [SB-1:0]        pick_lnk_r;
  logic [ADDR_BITS-1:0] pick_off_r;
  logic [REM_BITS-1:0]  pick_size_r;
  logic [SB-1:0]        slot_r;
  logic [SB-1:0]        fp_r;
  logic [SB-1:0]        fx_r;
  logic [REM_BITS-1:0]  fsize_r;
  logic [1:0]           status_r;
  logic [ADDR_BITS-1:0] res_addr_r;

  // Cell store ports
  cell_we_t             we;
  logic [SB-1:0]        wr_idx, nxt_idx, nxt_d, prv_idx, prv_d, rd_idx;
  logic [ADDR_BITS-1:0] off_d, rd_off;
  logic [REM_BITS-1:0]  size_d, rd_size;
  logic [SB-1:0]        rd_nxt, rd_prv;

  bfa_cell_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .we      (we),
    .wr_idx  (wr_idx),
    .off_d   (off_d),
    .size_d  (size_d),
    .nxt_idx (nxt_idx),
    .nxt_d   (nxt_d),
    .prv_idx (prv_idx),
    .prv_d   (prv_d),
    .rd_idx  (rd_idx),
    .rd_off  (rd_off),
    .rd_size (rd_size),
    .rd_nxt  (rd_nxt),
    .rd_prv  (rd_prv)
  );

  // Spare slot stack; entries below the low mark are never written, their slot is computed from the index
  logic [SB-1:0] stk_mem [SLOTS];
  logic [SB-1:0] stk_q;
  logic [SB-1:0] stk_top;
  logic [SB-1:0] stk_slot;
  logic          push;

  assign stk_top = SB'(count_r - CB'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[SB'(count_r)] <= cur_r;
    end
    stk_q <= stk_mem[stk_top];
  end

  always_comb begin
    if ((count_r - CB'(1)) < low_r) begin
      stk_slot = SB'(SLOTS - 1) - stk_top;
    end else begin
      stk_slot = stk_q;
    end
  end

  // Unit, rounded request and init size from the live registers
  logic [LOG_BITS-1:0]  ul;
  logic [UNIT_BITS-1:0] unit;
  logic [REM_BITS-1:0]  umask;
  logic [REM_BITS-1:0]  need;
  logic [REM_BITS-1:0]  hb;
  logic [REM_BITS-1:0]  sz;
  logic [REM_BITS-1:0]  two_units;

  always_comb begin
    if (unit_log2_r < LOG_BITS'(2)) begin
      ul = LOG_BITS'(2);
    end else if (unit_log2_r > LOG_BITS'(8)) begin
      ul = LOG_BITS'(8);
    end else begin
      ul = unit_log2_r;
    end
    unit      = UNIT_BITS'(1) << ul;
    umask     = REM_BITS'(unit - UNIT_BITS'(1));
    need      = ((REM_BITS'(in_request_bytes) + umask) & ~umask) + REM_BITS'(unit);
    hb        = (heap_bytes_r > HEAP_LIMIT) ? HEAP_LIMIT : heap_bytes_r;
    two_units = REM_BITS'(unit) << 1;
    sz        = hb & ~umask;
    if (sz < two_units) begin
      sz = two_units;
    end
  end

  // Gap between the held cell and the one just read
  logic signed [GAP_BITS-1:0] gap;
  logic signed [GAP_BITS-1:0] diff;
  logic [SB-1:0]              walk_nx;
  logic [SB-1:0]              walk_end;
  logic                       exact;
  logic                       better;

  always_comb begin
    if (rev_r) begin
      gap = $signed(GAP_BITS'(cur_off_r)) - $signed(GAP_BITS'(rd_off))
            - $signed(GAP_BITS'(rd_size));
      walk_nx  = rd_prv;
      walk_end = HEAD;
    end else begin
      gap = $signed(GAP_BITS'(rd_off)) - $signed(GAP_BITS'(cur_off_r))
            - $signed(GAP_BITS'(cur_size_r));
      walk_nx  = rd_nxt;
      walk_end = TAIL;
    end
    diff   = gap - $signed(GAP_BITS'(need_r));
    exact  = (diff == '0);
    better = (diff > 0) && (diff < $signed(best_r));
  end

  // New cell offset and free checks
  logic [ADDR_BITS-1:0] new_off;
  logic                 free_hit;

  assign new_off  = rev_r ? (pick_off_r - need_r[ADDR_BITS-1:0])
                          : (pick_off_r + pick_size_r[ADDR_BITS-1:0]);
  assign free_hit = (cur_r >= SB'(2)) &&
                    ((REM_BITS'(rd_off) + REM_BITS'(unit_r)) == REM_BITS'(addr_r));

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign push     = (state_r == S_UNLINK);

  // Read address and cell store writes
  always_comb begin
    rd_idx  = HEAD;
    we      = '0;
    wr_idx  = slot_r;
    off_d   = new_off;
    size_d  = need_r;
    nxt_idx = slot_r;
    nxt_d   = pick_lnk_r;
    prv_idx = slot_r;
    prv_d   = pick_r;
    case (state_r)
      S_IDLE: begin
        rd_idx = (op_t'(in_opcode) == OP_ALLOC_REV) ? TAIL : HEAD;
      end
      S_INIT_H: begin
        we      = '{off_size: 1'b1, nxt: 1'b1, prv: 1'b1};
        wr_idx  = HEAD;
        off_d   = '0;
        size_d  = REM_BITS'(unit_r);
        nxt_idx = HEAD;
        nxt_d   = TAIL;
        prv_idx = HEAD;
        prv_d   = HEAD;
      end
      S_INIT_T: begin
        we      = '{off_size: 1'b1, nxt: 1'b1, prv: 1'b1};
        wr_idx  = TAIL;
        off_d   = ADDR_BITS'(size_r - REM_BITS'(unit_r));
        size_d  = REM_BITS'(unit_r);
        nxt_idx = TAIL;
        nxt_d   = TAIL;
        prv_idx = TAIL;
        prv_d   = HEAD;
      end
      S_FIRST: begin
        rd_idx = rev_r ? rd_prv : rd_nxt;
      end
      S_WALK: begin
        rd_idx = walk_nx;
      end
      S_PLACE: begin
        we    = '{off_size: 1'b1, nxt: 1'b1, prv: 1'b1};
        nxt_d = rev_r ? pick_r : pick_lnk_r;
        prv_d = rev_r ? pick_lnk_r : pick_r;
      end
      S_LINK: begin
        we      = '{off_size: 1'b0, nxt: 1'b1, prv: 1'b1};
        nxt_idx = rev_r ? pick_lnk_r : pick_r;
        nxt_d   = slot_r;
        prv_idx = rev_r ? pick_r : pick_lnk_r;
        prv_d   = slot_r;
      end
      S_FREE_H: begin
        rd_idx = rd_nxt;
      end
      S_FREE_W: begin
        rd_idx = rd_nxt;
      end
      S_UNLINK: begin
        we      = '{off_size: 1'b0, nxt: 1'b1, prv: 1'b1};
        nxt_idx = fp_r;
        nxt_d   = fx_r;
        prv_idx = fx_r;
        prv_d   = fp_r;
      end
      default: ;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      inited_r   <= 1'b0;
      count_r    <= '0;
      low_r      <= '0;
      free_r     <= '0;
      free_low_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the result beat once taken, unless a new one loads this cycle
      if (out_valid && !out_stall && state_r != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            unit_r     <= unit;
            need_r     <= need;
            addr_r     <= in_free_address;
            size_r     <= sz;
            rev_r      <= (op_t'(in_opcode) == OP_ALLOC_REV);
            status_r   <= ST_OK;
            res_addr_r <= '0;
            case (op_t'(in_opcode))
              OP_INIT: state_r <= S_INIT_H;
              OP_ALLOC_FWD, OP_ALLOC_REV: begin
                if (count_r == '0 || !inited_r) begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_FIRST;
                end
              end
              OP_FREE: begin
                if (in_free_address == '0) begin
                  state_r <= S_DONE;
                end else if (!inited_r) begin
                  status_r <= ST_UNKNOWN;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_FREE_H;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_INIT_H: state_r <= S_INIT_T;
        S_INIT_T: begin
          inited_r   <= 1'b1;
          count_r    <= CB'(MAX_BLOCKS);
          low_r      <= CB'(MAX_BLOCKS);
          free_r     <= size_r - (REM_BITS'(unit_r) << 1);
          free_low_r <= size_r - (REM_BITS'(unit_r) << 1);
          state_r    <= S_DONE;
        end
        S_FIRST: begin
          slot_r     <= stk_slot;
          cur_r      <= rev_r ? TAIL : HEAD;
          cur_off_r  <= rd_off;
          cur_size_r <= rd_size;
          nx_r       <= rev_r ? rd_prv : rd_nxt;
          cnt_r      <= '0;
          best_r     <= BEST_INIT;
          found_r    <= 1'b0;
          state_r    <= S_WALK;
        end
        S_WALK: begin
          if (exact || better) begin
            found_r     <= 1'b1;
            best_r      <= diff;
            pick_r      <= cur_r;
            pick_lnk_r  <= nx_r;
            pick_off_r  <= cur_off_r;
            pick_size_r <= cur_size_r;
          end
          cnt_r      <= cnt_r + WB'(1);
          cur_r      <= nx_r;
          cur_off_r  <= rd_off;
          cur_size_r <= rd_size;
          nx_r       <= walk_nx;
          if (exact || better) begin
            if (exact || nx_r == walk_end || cnt_r == WB'(SLOTS - 1)) begin
              state_r <= S_PLACE;
            end
          end else if (nx_r == walk_end || cnt_r == WB'(SLOTS - 1)) begin
            if (found_r) begin
              state_r <= S_PLACE;
            end else begin
              status_r <= ST_NO_FIT;
              state_r  <= S_DONE;
            end
          end
        end
        S_PLACE: begin
          count_r <= count_r - CB'(1);
          if (low_r > count_r - CB'(1)) begin
            low_r <= count_r - CB'(1);
          end
          if (need_r > free_r) begin
            free_r     <= '0;
            free_low_r <= '0;
          end else begin
            free_r <= free_r - need_r;
            if (free_low_r > free_r - need_r) begin
              free_low_r <= free_r - need_r;
            end
          end
          res_addr_r <= new_off + ADDR_BITS'(unit_r);
          state_r    <= S_LINK;
        end
        S_LINK: state_r <= S_DONE;
        S_FREE_H: begin
          cur_r <= rd_nxt;
          cnt_r <= '0;
          if (rd_nxt == TAIL) begin
            status_r <= ST_UNKNOWN;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_FREE_W;
          end
        end
        S_FREE_W: begin
          if (free_hit) begin
            fp_r    <= rd_prv;
            fx_r    <= rd_nxt;
            fsize_r <= rd_size;
            state_r <= S_UNLINK;
          end else begin
            cur_r <= rd_nxt;
            cnt_r <= cnt_r + WB'(1);
            if (rd_nxt == TAIL || cnt_r == WB'(SLOTS - 1)) begin
              status_r <= ST_UNKNOWN;
              state_r  <= S_DONE;
            end
          end
        end
        S_UNLINK: begin
          free_r  <= free_r + fsize_r;
          count_r <= count_r + CB'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            out_status        <= status_r;
            out_address       <= (status_r == ST_OK) ? res_addr_r : '0;
            out_remainder     <= free_r;
            out_remainder_min <= free_low_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the best-fit block allocator.
module tb_top;
  import bfa_pkg::*;

  localparam int SLOT_COUNT = 258;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_opcode;
  logic [ADDR_BITS-1:0] in_request_bytes;
  logic [ADDR_BITS-1:0] in_free_address;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [ADDR_BITS-1:0] out_address;
  logic [REM_BITS-1:0] out_remainder;
  logic [REM_BITS-1:0] out_remainder_min;
  logic cfg_we;
  logic cfg_index;
  logic [REM_BITS-1:0] cfg_wdata;

  typedef struct packed {
    logic [1:0] status;
    logic [ADDR_BITS-1:0] address;
    logic [REM_BITS-1:0] remainder;
    logic [REM_BITS-1:0] remainder_min;
  } heap_answer_t;

  best_fit_block_allocator dut (.*);

  // Shadow allocator state
  logic [3:0] sh_unit_log2;
  logic [REM_BITS-1:0] sh_heap_bytes;
  longint sh_off [SLOT_COUNT];
  longint sh_size [SLOT_COUNT];
  int sh_next [SLOT_COUNT];
  int sh_prev [SLOT_COUNT];
  int sh_spare [SLOT_COUNT];
  int sh_spare_cnt;
  longint sh_free;
  longint sh_free_low;

  heap_answer_t expected_answers[$];
  logic [ADDR_BITS-1:0] live_addrs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off;
  bit rx_noise;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unit_bytes();
    int l;
    l = sh_unit_log2;
    if (l < 2) l = 2;
    if (l > 8) l = 8;
    return longint'(1) << l;
  endfunction

  function automatic void heap_rebuild();
    longint u;
    longint sz;
    u = unit_bytes();
    sz = (sh_heap_bytes > 25'h1000000) ? 64'h1000000 : longint'(sh_heap_bytes);
    sz = sz & ~(u - 1);
    if (sz < 2 * u) sz = 2 * u;
    sh_off[0] = 0; sh_size[0] = u; sh_next[0] = 1; sh_prev[0] = 0;
    sh_off[1] = sz - u; sh_size[1] = u; sh_next[1] = 1; sh_prev[1] = 0;
    sh_spare_cnt = 0;
    for (int i = SLOT_COUNT; i > 2; i--) begin
      sh_spare[sh_spare_cnt] = i - 1;
      sh_spare_cnt++;
    end
    sh_free = sz - 2 * u;
    sh_free_low = sh_free;
  endfunction

  function automatic int heap_take(bit rev, longint req, output longint addr);
    longint u, need, best, gap;
    int cur, pick, nx, slot, p, x;
    u = unit_bytes();
    need = u + ((req + u - 1) & ~(u - 1));
    best = 64'h7FFFFFFF;
    cur = rev ? 1 : 0;
    pick = SLOT_COUNT;
    addr = 0;
    if (sh_spare_cnt == 0) return ST_FULL;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      nx = rev ? sh_prev[cur] : sh_next[cur];
      if (rev) gap = sh_off[cur] - sh_off[nx] - sh_size[nx];
      else gap = sh_off[nx] - sh_off[cur] - sh_size[cur];
      if (gap >= need) begin
        if (gap == need) begin
          pick = cur;
          break;
        end
        if (gap - need < best) begin
          best = gap - need;
          pick = cur;
        end
      end
      cur = nx;
      if (cur == (rev ? 0 : 1)) break;
    end
    if (pick >= SLOT_COUNT) return ST_NO_FIT;
    sh_spare_cnt--;
    slot = sh_spare[sh_spare_cnt];
    sh_size[slot] = need;
    if (rev) begin
      p = sh_prev[pick];
      sh_off[slot] = (sh_off[pick] - need) & 64'hFFFFFF;
      sh_prev[slot] = p; sh_next[slot] = pick;
      sh_next[p] = slot; sh_prev[pick] = slot;
    end else begin
      x = sh_next[pick];
      sh_off[slot] = (sh_off[pick] + sh_size[pick]) & 64'hFFFFFF;
      sh_prev[slot] = pick; sh_next[slot] = x;
      sh_prev[x] = slot; sh_next[pick] = slot;
    end
    sh_free = (need > sh_free) ? 0 : sh_free - need;
    if (sh_free_low > sh_free) sh_free_low = sh_free;
    addr = (sh_off[slot] + u) & 64'hFFFFFF;
    return ST_OK;
  endfunction

  function automatic int heap_release(longint addr);
    longint u;
    int cur, n, p, x;
    u = unit_bytes();
    if (addr == 0) return ST_OK;
    // Before the first init no block is linked
    if (sh_spare_cnt == 0 && sh_free == 0 && sh_next[0] == 0) return ST_UNKNOWN;
    cur = sh_next[0];
    for (n = 0; n < SLOT_COUNT && cur != 1; n++) begin
      if (cur >= 2 && sh_off[cur] + u == addr) break;
      cur = sh_next[cur];
    end
    if (n >= SLOT_COUNT || cur < 2) return ST_UNKNOWN;
    p = sh_prev[cur];
    x = sh_next[cur];
    sh_free += sh_size[cur];
    sh_next[p] = x;
    sh_prev[x] = p;
    sh_spare[sh_spare_cnt] = cur;
    sh_spare_cnt++;
    return ST_OK;
  endfunction

  function automatic heap_answer_t predict_answer(op_t op, logic [ADDR_BITS-1:0] req,
                                                  logic [ADDR_BITS-1:0] faddr);
    heap_answer_t a;
    longint addr;
    int st;
    addr = 0;
    st = ST_OK;
    case (op)
      OP_INIT: heap_rebuild();
      OP_ALLOC_FWD, OP_ALLOC_REV: st = heap_take(op == OP_ALLOC_REV, req, addr);
      default: st = heap_release(faddr);
    endcase
    a.status = st[1:0];
    a.address = (st == ST_OK) ? addr[ADDR_BITS-1:0] : '0;
    a.remainder = sh_free[REM_BITS-1:0];
    a.remainder_min = sh_free_low[REM_BITS-1:0];
    return a;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  // Send one beat and record its expected answer
  task automatic send_op(op_t op, logic [ADDR_BITS-1:0] req, logic [ADDR_BITS-1:0] faddr,
                         bit gaps = 1);
    heap_answer_t a;
    int g;
    g = gaps ? random_gap() : 0;
    // Leave valid low after the previous beat, plus a random gap
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_request_bytes <= req;
    in_free_address <= faddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = predict_answer(op, req, faddr);
    expected_answers.push_back(a);
    if (op != OP_FREE && a.status == ST_OK && a.address != 0) live_addrs.push_back(a.address);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [REM_BITS-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_UNIT_LOG2) sh_unit_log2 = val[3:0];
    else sh_heap_bytes = val;
  endtask

  task automatic free_random();
    int k;
    if (live_addrs.size() == 0) begin
      send_op(OP_FREE, 24'($urandom), 24'($urandom_range(1, 4096)));
      return;
    end
    k = $urandom_range(0, live_addrs.size() - 1);
    send_op(OP_FREE, 24'($urandom), live_addrs[k]);
    live_addrs.delete(k);
  endtask

  task automatic test_before_init();
    send_op(OP_ALLOC_FWD, 24'd16, 24'd0);
    send_op(OP_ALLOC_REV, 24'd16, 24'd0);
    send_op(OP_FREE, 24'd0, 24'd32);
    send_op(OP_FREE, 24'd0, 24'd0);
  endtask

  task automatic test_directed();
    logic [ADDR_BITS-1:0] a1;
    send_op(OP_INIT, 24'hFFFFFF, 24'hFFFFFF);
    send_op(OP_ALLOC_FWD, 24'd0, 24'd0);
    send_op(OP_ALLOC_REV, 24'd1, 24'd0);
    send_op(OP_ALLOC_FWD, 24'hFFFFFF, 24'd0);
    send_op(OP_ALLOC_REV, 24'd100, 24'd0);
    send_op(OP_FREE, 24'd0, 24'd0);
    send_op(OP_FREE, 24'd0, 24'hFFFFFF);
    send_op(OP_FREE, 24'd0, 24'd16);
    drain();
    a1 = live_addrs[0];
    live_addrs.delete(0);
    send_op(OP_FREE, 24'd0, a1);
    send_op(OP_FREE, 24'd0, a1);
    // refill the space freed next to the head cell
    send_op(OP_ALLOC_FWD, 24'd0, 24'd0);
    write_reg(REG_UNIT_LOG2, 25'd0);
    send_op(OP_ALLOC_FWD, 24'd5, 24'd0);
    write_reg(REG_UNIT_LOG2, 25'd15);
    send_op(OP_ALLOC_REV, 24'd5, 24'd0);
    write_reg(REG_HEAP_BYTES, 25'h1FFFFFF);
    send_op(OP_INIT, 24'd0, 24'd0);
    live_addrs.delete();
    send_op(OP_ALLOC_REV, 24'hFFFFFF, 24'd0);
    write_reg(REG_HEAP_BYTES, 25'd0);
    send_op(OP_INIT, 24'd0, 24'd0);
    live_addrs.delete();
    send_op(OP_ALLOC_FWD, 24'd0, 24'd0);
  endtask

  // Exhaust the table, then free everything
  task automatic test_table_full();
    write_reg(REG_UNIT_LOG2, 25'd2);
    write_reg(REG_HEAP_BYTES, 25'h1000000);
    send_op(OP_INIT, 24'd0, 24'd0);
    live_addrs.delete();
    for (int i = 0; i < 260; i++)
      send_op(($urandom_range(0, 1) != 0) ? OP_ALLOC_FWD : OP_ALLOC_REV,
              24'($urandom_range(0, 64)), 24'd0, 0);
    while (live_addrs.size() != 0) free_random();
  endtask

  // Stall the receiver long enough for the block to back up
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_op(OP_ALLOC_FWD, 24'($urandom_range(0, 200)), 24'd0, 0);
    join
    drain();
  endtask

  task automatic test_random(int count, logic [3:0] ul, logic [REM_BITS-1:0] hb);
    int r;
    write_reg(REG_UNIT_LOG2, 25'(ul));
    write_reg(REG_HEAP_BYTES, hb);
    send_op(OP_INIT, 24'($urandom), 24'($urandom));
    live_addrs.delete();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_op(OP_INIT, 24'($urandom), 24'($urandom));
        live_addrs.delete();
      end else if (r < 50) begin
        send_op(($urandom_range(0, 1) != 0) ? OP_ALLOC_FWD : OP_ALLOC_REV,
                ($urandom_range(0, 30) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000)),
                24'($urandom));
      end else if (r < 90) begin
        free_random();
      end else begin
        send_op(OP_FREE, 24'($urandom), ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom));
      end
      if (live_addrs.size() > 200) free_random();
    end
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    heap_answer_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d", $time, out_status);
          errors++;
        end else begin
          e = expected_answers.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_address !== e.address) begin
            $display("%0t: address exp %0h got %0h", $time, e.address, out_address);
            errors++;
          end
          if (out_remainder !== e.remainder) begin
            $display("%0t: remainder exp %0d got %0d", $time, e.remainder, out_remainder);
            errors++;
          end
          if (out_remainder_min !== e.remainder_min) begin
            $display("%0t: remainder_min exp %0d got %0d", $time, e.remainder_min,
                     out_remainder_min);
            errors++;
          end
        end
      end
      if (hold_off) out_stall <= 1'b1;
      else if (rx_noise) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= 1'b0;
    end
  end

  // Watchdog on accepted beats, taken results and register writes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    hold_off = 1'b0;
    rx_noise = 1'b0;
    sh_unit_log2 = UNIT_LOG2_RST;
    sh_heap_bytes = HEAP_BYTES_RST;
    sh_spare_cnt = 0;
    sh_free = 0;
    sh_free_low = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sh_off[i] = 0; sh_size[i] = 0; sh_next[i] = 0; sh_prev[i] = 0; sh_spare[i] = 0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_INIT;
    in_request_bytes = '0;
    in_free_address = '0;
    cfg_we = 1'b0;
    cfg_index = REG_UNIT_LOG2;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_init();
    test_directed();
    rx_noise = 1'b1;
    test_table_full();
    test_backpressure();
    test_random(450, 4'd4, 25'd65536);
    drain();
    test_random(400, 4'd2, 25'd4096);
    test_random(250, 4'd8, 25'h1000000);
    test_random(250, 4'd3, 25'd20000);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
sv/bfa_pkg.sv
sv/bfa_cell_store.sv
sv/best_fit_block_allocator.sv
dv/tb_top.sv
